[rtl/assert_macros.svh]
// Assertion macros included by the hash table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at each rising edge of clk, suspended while arst_n is low.
`define HHT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at each rising edge of clk, also during reset.
`define HHT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/hht_pkg.sv]
// ----------------------------------------------------------------------------
// hht_pkg
// Constants, codes and hash helpers of the hopscotch hash table.
// ----------------------------------------------------------------------------
package hht_pkg;

	localparam int HHT_BUCKETS_LOG2 = 10;
	localparam int HHT_NEIGHBORHOOD = 32;
	localparam int HHT_KEY_BYTES    = 8;
	localparam int HHT_VALUE_WIDTH  = 32;

	localparam int KEY_W = 64;
	localparam int VAL_W = 32;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;

	localparam op_t OP_LOOKUP = 2'd0;
	localparam op_t OP_INSERT = 2'd1;
	localparam op_t OP_REMOVE = 2'd2;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NOTFOUND = 2'd1;
	localparam status_t ST_FULL     = 2'd2;

	// One byte round of the one-at-a-time hash.
	function automatic logic [31:0] oaat_step(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] t;
		t = h + {24'd0, b};
		t = t + (t << 10);
		t = t ^ (t >> 6);
		return t;
	endfunction

	// Final avalanche of the one-at-a-time hash.
	function automatic logic [31:0] oaat_final(input logic [31:0] h);
		logic [31:0] t;
		t = h + (h << 3);
		t = t ^ (t >> 11);
		t = t + (t << 15);
		return t;
	endfunction

endpackage

[rtl/hht_req_if.sv]
// ----------------------------------------------------------------------------
// hht_req_if
// Request channel: operation, key and value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hht_req_if
	import hht_pkg::*;
();
	logic        valid;
	logic        ready;
	op_t         op;
	logic [63:0] key;
	logic [31:0] value;

	modport source (output valid, output op, output key, output value, input ready);
	modport sink (input valid, input op, input key, input value, output ready);
endinterface

[rtl/hht_rsp_if.sv]
// ----------------------------------------------------------------------------
// hht_rsp_if
// Response channel: status and returned value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hht_rsp_if
	import hht_pkg::*;
();
	logic        valid;
	logic        ready;
	status_t     status;
	logic [31:0] value_out;

	modport source (output valid, output status, output value_out, input ready);
	modport sink (input valid, input status, input value_out, output ready);
endinterface

[rtl/hht_ram.sv]
// ----------------------------------------------------------------------------
// hht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

[rtl/hopscotch_hash_table.sv]
// ----------------------------------------------------------------------------
// hopscotch_hash_table
// Hopscotch hash table with one-at-a-time hashing, kept in two RAMs.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | op, key, value
//  rsp     | out | status, value_out
//
// Hashing folds in one key byte per cycle, then the final avalanche and the home map read.
// Lookup and remove read the home map, then check the bucket of each set map bit until a
// key matches; a remove adds one or two writes. Insert probes bucket by bucket and hops by
// trying each distance and moving entries, all through the single metadata RAM read port.
// After reset a clearing pass zeroes every bucket of the metadata RAM.
// A new request is taken while the previous response still waits in its register.
module hopscotch_hash_table
	import hht_pkg::*;
#(
	parameter int BUCKETS_LOG2 = HHT_BUCKETS_LOG2,
	parameter int NEIGHBORHOOD = HHT_NEIGHBORHOOD,
	parameter int KEY_BYTES    = HHT_KEY_BYTES,
	parameter int VALUE_WIDTH  = HHT_VALUE_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	hht_req_if.sink     req,
	hht_rsp_if.source   rsp
);
	localparam int AW   = BUCKETS_LOG2;
	localparam int IW   = AW + 1;
	localparam int CW   = (IW > 6) ? IW : 6;
	localparam int NB   = NEIGHBORHOOD;
	localparam int NBW  = $clog2(NB);
	localparam int BCW  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam int MW   = NB + 1;
	localparam int DW   = KEY_W + VALUE_WIDTH;
	localparam int SIZE = 1 << AW;
	localparam logic [IW-1:0]    SIZE_I   = IW'(1) << AW;
	localparam logic [CW-1:0]    SIZE_C   = CW'(1) << AW;
	localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
		((KEY_W'(1) << (8 * KEY_BYTES)) - KEY_W'(1));

	localparam logic [4:0] S_CLR      = 5'd0;
	localparam logic [4:0] S_IDLE     = 5'd1;
	localparam logic [4:0] S_HASH     = 5'd2;
	localparam logic [4:0] S_FIN      = 5'd3;
	localparam logic [4:0] S_HOME_RD  = 5'd4;
	localparam logic [4:0] S_HOME_CK  = 5'd5;
	localparam logic [4:0] S_SCAN_RD  = 5'd6;
	localparam logic [4:0] S_SCAN_CK  = 5'd7;
	localparam logic [4:0] S_REM_W1   = 5'd8;
	localparam logic [4:0] S_REM_W2   = 5'd9;
	localparam logic [4:0] S_PROBE_RD = 5'd10;
	localparam logic [4:0] S_PROBE_CK = 5'd11;
	localparam logic [4:0] S_HOP_RD   = 5'd12;
	localparam logic [4:0] S_HOP_CK   = 5'd13;
	localparam logic [4:0] S_MOVE_RD  = 5'd14;
	localparam logic [4:0] S_MOVE_CK  = 5'd15;
	localparam logic [4:0] S_MOVE_W2  = 5'd16;
	localparam logic [4:0] S_MOVE_W3  = 5'd17;
	localparam logic [4:0] S_INS_W1   = 5'd18;
	localparam logic [4:0] S_INS_W2   = 5'd19;
	localparam logic [4:0] S_DONE     = 5'd20;

	// Lowest set bit of a neighborhood map.
	function automatic logic [NBW-1:0] low_bit(input logic [NB-1:0] m);
		logic [NBW-1:0] r;
		r = '0;
		for (int k = NB - 1; k >= 0; k--) begin
			if (m[k]) begin
				r = NBW'(k);
			end
		end
		return r;
	endfunction

	// Map of the slots that lie inside the table for a given home bucket.
	function automatic logic [NB-1:0] in_table(input logic [AW-1:0] h);
		logic [NB-1:0] r;
		for (int k = 0; k < NB; k++) begin
			r[k] = (CW'(h) + CW'(k)) < SIZE_C;
		end
		return r;
	endfunction

	// Handle as stored, VALUE_WIDTH bits.
	function automatic logic [VALUE_WIDTH-1:0] to_store(input logic [VAL_W-1:0] v);
		logic [VALUE_WIDTH-1:0] r;
		for (int k = 0; k < VALUE_WIDTH; k++) begin
			r[k] = (k < VAL_W) ? v[k % VAL_W] : 1'b0;
		end
		return r;
	endfunction

	// Stored handle as returned, 32 bits.
	function automatic logic [VAL_W-1:0] from_store(input logic [VALUE_WIDTH-1:0] v);
		logic [VAL_W-1:0] r;
		for (int k = 0; k < VAL_W; k++) begin
			r[k] = (k < VALUE_WIDTH) ? v[k % VALUE_WIDTH] : 1'b0;
		end
		return r;
	endfunction

	logic [4:0]        state_q;
	logic [AW-1:0]     clr_q;
	op_t               op_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  value_q;
	logic [BCW-1:0]    byte_q;
	logic [31:0]       h_q;
	logic [AW-1:0]     home_q;
	logic              home_valid_q;
	logic [NB-1:0]     home_map_q;
	logic [NB-1:0]     scan_mask_q;
	logic [NBW-1:0]    slot_q;
	logic [NB-1:0]     slot_map_q;
	logic [IW-1:0]     i_q;
	logic [NB-1:0]     free_map_q;
	logic [NBW-1:0]    j_q;
	logic [NBW-1:0]    off_q;
	logic [NB-1:0]     base_map_q;
	logic              base_valid_q;
	logic [NB-1:0]     src_map_q;
	status_t           res_status_q;
	logic [VAL_W-1:0]  res_value_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [VAL_W-1:0]  out_value_q;

	logic              meta_wr_en;
	logic [AW-1:0]     meta_wr_addr;
	logic [MW-1:0]     meta_wdata;
	logic [AW-1:0]     meta_rd_addr;
	logic [MW-1:0]     meta_rdata;
	logic              data_wr_en;
	logic [AW-1:0]     data_wr_addr;
	logic [DW-1:0]     data_wdata;
	logic [DW-1:0]     data_rdata;

	logic [NBW-1:0]    scan_slot;
	logic [AW-1:0]     slot_addr;
	logic [AW-1:0]     base_addr;
	logic [AW-1:0]     src_addr;
	logic [CW-1:0]     free_dist;
	logic [CW-1:0]     src_dist;
	logic [NB-1:0]     hop_newmap;
	logic [NBW-1:0]    rd_off;
	logic              key_hit;
	logic              out_free;

	// Address arithmetic shared by the states.
	assign scan_slot  = low_bit(scan_mask_q);
	assign slot_addr  = home_q + AW'(slot_q);
	assign base_addr  = AW'(i_q) - AW'(j_q);
	assign src_addr   = base_addr + AW'(off_q);
	assign free_dist  = CW'(i_q) - CW'(home_q);
	assign src_dist   = CW'(src_addr) - CW'(home_q);
	assign hop_newmap = (base_map_q & ~(NB'(1) << off_q)) | (NB'(1) << j_q);
	assign rd_off     = low_bit(meta_rdata[NB-1:0]);
	assign key_hit    = meta_rdata[NB] &&
		((data_rdata[KEY_W-1:0] & KEY_MASK) == (key_q & KEY_MASK));
	assign out_free   = !out_valid_q || rsp.ready;

	// Metadata RAM: {valid, neighborhood map} per bucket.
	hht_ram #(.WIDTH(MW), .DEPTH(SIZE)) u_meta (
		.clk     (clk),
		.wr_en   (meta_wr_en),
		.wr_addr (meta_wr_addr),
		.wr_data (meta_wdata),
		.rd_addr (meta_rd_addr),
		.rd_data (meta_rdata)
	);

	// Data RAM: {handle, key} per bucket.
	hht_ram #(.WIDTH(DW), .DEPTH(SIZE)) u_data (
		.clk     (clk),
		.wr_en   (data_wr_en),
		.wr_addr (data_wr_addr),
		.wr_data (data_wdata),
		.rd_addr (meta_rd_addr),
		.rd_data (data_rdata)
	);

	// Read address and write ports as the state requires.
	always_comb begin
		meta_wr_en   = 1'b0;
		meta_wr_addr = home_q;
		meta_wdata   = '0;
		data_wr_en   = 1'b0;
		data_wr_addr = AW'(i_q);
		data_wdata   = {to_store(value_q), key_q};
		meta_rd_addr = home_q;
		unique case (state_q)
			S_CLR: begin
				meta_wr_en   = 1'b1;
				meta_wr_addr = clr_q;
			end
			S_SCAN_RD: meta_rd_addr = home_q + AW'(scan_slot);
			S_REM_W1: begin
				meta_wr_en = 1'b1;
				meta_wdata = {home_valid_q && (slot_q != '0),
					home_map_q & ~(NB'(1) << slot_q)};
			end
			S_REM_W2: begin
				meta_wr_en   = 1'b1;
				meta_wr_addr = slot_addr;
				meta_wdata   = {1'b0, slot_map_q};
			end
			S_PROBE_RD: meta_rd_addr = AW'(i_q);
			S_HOP_RD:   meta_rd_addr = base_addr;
			S_MOVE_RD:  meta_rd_addr = src_addr;
			S_MOVE_CK: begin
				data_wr_en   = 1'b1;
				data_wdata   = data_rdata;
				meta_wr_en   = 1'b1;
				meta_wr_addr = AW'(i_q);
				meta_wdata   = {1'b1, free_map_q};
			end
			S_MOVE_W2: begin
				meta_wr_en   = 1'b1;
				meta_wr_addr = src_addr;
				meta_wdata   = {1'b0, (off_q == '0) ? hop_newmap : src_map_q};
			end
			S_MOVE_W3: begin
				meta_wr_en   = 1'b1;
				meta_wr_addr = base_addr;
				meta_wdata   = {base_valid_q, hop_newmap};
			end
			S_INS_W1: begin
				data_wr_en   = 1'b1;
				meta_wr_en   = 1'b1;
				meta_wr_addr = AW'(i_q);
				meta_wdata   = {1'b1, (free_dist == '0) ? (free_map_q | NB'(1)) : free_map_q};
			end
			S_INS_W2: begin
				meta_wr_en = 1'b1;
				meta_wdata = {home_valid_q, home_map_q | (NB'(1) << NBW'(free_dist))};
			end
			default: begin
			end
		endcase
	end

	// Operation sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == {AW{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (byte_q == BCW'(KEY_BYTES - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN:     state_q <= S_HOME_RD;
				S_HOME_RD: state_q <= S_HOME_CK;
				S_HOME_CK: begin
					priority if (op_q == OP_LOOKUP || op_q == OP_REMOVE) begin
						state_q <= ((meta_rdata[NB-1:0] & in_table(home_q)) == '0) ?
							S_DONE : S_SCAN_RD;
					end else if (op_q == OP_INSERT) begin
						state_q <= meta_rdata[NB] ? S_PROBE_RD : S_INS_W1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CK;
				S_SCAN_CK: begin
					priority if (key_hit) begin
						state_q <= (op_q == OP_REMOVE) ? S_REM_W1 : S_DONE;
					end else if (scan_mask_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_REM_W1: state_q <= (slot_q != '0) ? S_REM_W2 : S_DONE;
				S_REM_W2: state_q <= S_DONE;
				S_PROBE_RD: state_q <= (i_q == SIZE_I) ? S_DONE : S_PROBE_CK;
				S_PROBE_CK: begin
					priority if (meta_rdata[NB]) begin
						state_q <= S_PROBE_RD;
					end else if (free_dist >= CW'(NB)) begin
						state_q <= S_HOP_RD;
					end else begin
						state_q <= S_INS_W1;
					end
				end
				S_HOP_RD: state_q <= S_HOP_CK;
				S_HOP_CK: begin
					priority if (meta_rdata[NB-1:0] != '0 && rd_off < j_q) begin
						state_q <= S_MOVE_RD;
					end else if (j_q == NBW'(NB - 1)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_HOP_RD;
					end
				end
				S_MOVE_RD: state_q <= S_MOVE_CK;
				S_MOVE_CK: state_q <= S_MOVE_W2;
				S_MOVE_W2: begin
					priority if (off_q != '0) begin
						state_q <= S_MOVE_W3;
					end else if (src_dist >= CW'(NB)) begin
						state_q <= S_HOP_RD;
					end else begin
						state_q <= S_INS_W1;
					end
				end
				S_MOVE_W3: state_q <= (src_dist >= CW'(NB)) ? S_HOP_RD : S_INS_W1;
				S_INS_W1:  state_q <= (free_dist != '0) ? S_INS_W2 : S_DONE;
				S_INS_W2:  state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLR;
			endcase
		end
	end

	// Working registers of the current item.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q         <= req.op;
				key_q        <= req.key;
				value_q      <= req.value;
				byte_q       <= '0;
				h_q          <= '0;
				res_status_q <= ST_NOTFOUND;
				res_value_q  <= '0;
			end
			S_HASH: begin
				h_q    <= oaat_step(h_q, 8'(key_q >> {byte_q, 3'b000}));
				byte_q <= byte_q + BCW'(1);
			end
			S_FIN: home_q <= AW'(oaat_final(h_q));
			S_HOME_CK: begin
				home_valid_q <= meta_rdata[NB];
				home_map_q   <= meta_rdata[NB-1:0];
				scan_mask_q  <= meta_rdata[NB-1:0] & in_table(home_q);
				free_map_q   <= meta_rdata[NB-1:0];
				i_q          <= IW'(home_q) + (meta_rdata[NB] ? IW'(1) : IW'(0));
			end
			S_SCAN_RD: begin
				slot_q      <= scan_slot;
				scan_mask_q <= scan_mask_q & ~(NB'(1) << scan_slot);
			end
			S_SCAN_CK: begin
				slot_map_q <= meta_rdata[NB-1:0];
				if (key_hit) begin
					res_status_q <= ST_OK;
					res_value_q  <= from_store(data_rdata[DW-1:KEY_W]);
				end
			end
			S_PROBE_RD: begin
				if (i_q == SIZE_I) begin
					res_status_q <= ST_FULL;
				end
			end
			S_PROBE_CK: begin
				free_map_q <= meta_rdata[NB-1:0];
				j_q        <= NBW'(1);
				if (meta_rdata[NB]) begin
					i_q <= i_q + IW'(1);
				end
			end
			S_HOP_CK: begin
				base_map_q   <= meta_rdata[NB-1:0];
				base_valid_q <= meta_rdata[NB];
				off_q        <= rd_off;
				if (!(meta_rdata[NB-1:0] != '0 && rd_off < j_q)) begin
					j_q <= j_q + NBW'(1);
					if (j_q == NBW'(NB - 1)) begin
						res_status_q <= ST_FULL;
					end
				end
			end
			S_MOVE_CK: src_map_q <= meta_rdata[NB-1:0];
			S_MOVE_W2: begin
				if (off_q == '0) begin
					free_map_q <= hop_newmap;
					i_q        <= IW'(src_addr);
					j_q        <= NBW'(1);
				end else begin
					free_map_q <= src_map_q;
				end
			end
			S_MOVE_W3: begin
				i_q <= IW'(src_addr);
				j_q <= NBW'(1);
			end
			S_INS_W1: res_status_q <= ST_OK;
			default: begin
			end
		endcase
	end

	// Response register: a finished result waits here until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
		end
	end

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.value_out = out_value_q;

	`include "assert_macros.svh"

	`HHT_ASSERT(a_clear_zero, (state_q == S_CLR) |-> (meta_wr_en && meta_wdata == '0), "clear pass must write zero")
	`HHT_ASSERT(a_accept_hash, (req.valid && req.ready) |=> (state_q == S_HASH), "a transfer must start hashing")
	`HHT_ASSERT(a_scan_nonempty, (state_q == S_SCAN_RD) |-> (scan_mask_q != '0), "scan with empty mask")
	`HHT_ASSERT(a_hop_far, (state_q == S_HOP_RD) |-> (free_dist >= CW'(NB) && j_q != '0), "hop while near home")
	`HHT_ASSERT_ALWAYS(a_reset_clear, (!arst_n) |-> (state_q == S_CLR && !out_valid_q), "reset must clear")
endmodule

[tb/hht_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hht_checker
// Watches the request and response channels of the hash table. Every accepted
// request is run through a bucket-level model of the table, and every accepted
// response is compared field by field with the oldest predicted response.
// ----------------------------------------------------------------------------
module hht_checker
	import hht_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	hht_req_if   req,
	hht_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);

	localparam int NBUCKETS = 1 << HHT_BUCKETS_LOG2;
	localparam int NB       = HHT_NEIGHBORHOOD;

	typedef struct packed {
		status_t     status;
		logic [31:0] value_out;
	} rsp_item_t;

	// Model copy of the table contents.
	logic [63:0]   slot_key   [NBUCKETS];
	logic [31:0]   slot_value [NBUCKETS];
	logic          slot_used  [NBUCKETS];
	logic [NB-1:0] nbr_map    [NBUCKETS];

	rsp_item_t expected_rsp_q[$];

	// Home bucket of a key: one-at-a-time hash, low bits.
	function automatic int unsigned home_bucket(input logic [63:0] key);
		logic [31:0] h;
		h = '0;
		for (int b = 0; b < HHT_KEY_BYTES; b++) begin
			h = h + {24'd0, key[8*b +: 8]};
			h = h + (h << 10);
			h = h ^ (h >> 6);
		end
		h = h + (h << 3);
		h = h ^ (h >> 11);
		h = h + (h << 15);
		return h & (NBUCKETS - 1);
	endfunction

	// Offset of the first matching live entry in the neighborhood, or -1.
	function automatic int find_entry(input int unsigned home, input logic [63:0] key);
		for (int i = 0; i < NB; i++) begin
			if (nbr_map[home][i] && (home + i) < NBUCKETS && slot_used[home + i] &&
					slot_key[home + i] == key)
				return i;
		end
		return -1;
	endfunction

	// Insert with linear probe and hopping; returns the response status.
	function automatic status_t insert_entry(input int unsigned home, input logic [63:0] key,
			input logic [31:0] value);
		int unsigned fr;
		int unsigned base;
		int off;
		logic moved;
		fr = home;
		while (fr < NBUCKETS && slot_used[fr])
			fr++;
		if (fr >= NBUCKETS)
			return ST_FULL;
		while (fr - home >= NB) begin
			moved = 1'b0;
			for (int j = 1; j < NB && !moved; j++) begin
				base = fr - j;
				if (nbr_map[base] != '0) begin
					off = 0;
					while (!nbr_map[base][off])
						off++;
					if (off < j) begin
						slot_key[fr]            = slot_key[base + off];
						slot_value[fr]          = slot_value[base + off];
						slot_used[fr]           = 1'b1;
						slot_used[base + off]   = 1'b0;
						nbr_map[base][off]      = 1'b0;
						nbr_map[base][j]        = 1'b1;
						fr    = base + off;
						moved = 1'b1;
					end
				end
			end
			if (!moved)
				return ST_FULL;
		end
		slot_key[fr]               = key;
		slot_value[fr]             = value;
		slot_used[fr]              = 1'b1;
		nbr_map[home][fr - home]   = 1'b1;
		return ST_OK;
	endfunction

	function automatic rsp_item_t table_response(input op_t op, input logic [63:0] key,
			input logic [31:0] value);
		rsp_item_t r;
		int unsigned home;
		int s;
		home = home_bucket(key);
		r.status    = ST_NOTFOUND;
		r.value_out = '0;
		if (op == OP_LOOKUP || op == OP_REMOVE) begin
			s = find_entry(home, key);
			if (s >= 0) begin
				r.status    = ST_OK;
				r.value_out = slot_value[home + s];
				if (op == OP_REMOVE) begin
					nbr_map[home][s]     = 1'b0;
					slot_used[home + s]  = 1'b0;
				end
			end
		end else if (op == OP_INSERT) begin
			r.status = insert_entry(home, key, value);
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending    = 0;
		for (int i = 0; i < NBUCKETS; i++) begin
			slot_used[i] = 1'b0;
			nbr_map[i]   = '0;
		end
	end

	// Predict on each request transfer and compare on each response transfer.
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n) begin
			if (req.valid && req.ready)
				expected_rsp_q.push_back(table_response(req.op, req.key, req.value));
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp_q.size() == 0) begin
					report("unexpected response", {30'd0, rsp.status}, 32'd0);
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.status !== want.status)
						report("status", {30'd0, rsp.status}, {30'd0, want.status});
					if (rsp.value_out !== want.value_out)
						report("value_out", rsp.value_out, want.value_out);
				end
			end
			pending = expected_rsp_q.size();
		end
	end

endmodule

[tb/hopscotch_hash_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hopscotch_hash_table_tb
// Drives lookups, inserts and removes into the hash table with random gaps on
// both channels and one long response stall. Keys are drawn mostly from two
// clustered pools, one near the table end and one mid-table, so that probing,
// hopping and the full cases are reached. The checker does the comparing.
// ----------------------------------------------------------------------------
module hopscotch_hash_table_tb;
	import hht_pkg::*;

	localparam op_t OP_UNUSED   = 2'd3;
	localparam int  N_RANDOM    = 480;
	localparam int  CYCLE_LIMIT = 1500000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycles;
	logic stall_now;

	logic [63:0] end_pool[$];
	logic [63:0] mid_pool[$];

	hht_req_if req ();
	hht_rsp_if rsp ();

	hopscotch_hash_table u_top (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	hht_checker u_chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending(pending));

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] rand_key();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		if ($urandom_range(0, 9) < 4)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 80);
		return $urandom_range(1, 4);
	endfunction

	// Fill a pool with keys whose home bucket lies in [lo, hi].
	task automatic fill_pool(ref logic [63:0] pool[$], input int n, input int lo, input int hi);
		logic [63:0] k;
		int unsigned h;
		while (pool.size() < n) begin
			k = rand_key();
			h = u_chk.home_bucket(k);
			if (h >= lo && h <= hi)
				pool.push_back(k);
		end
	endtask

	task automatic send(input op_t op, input logic [63:0] key, input logic [31:0] value);
		int g;
		g = gap_len();
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.op    <= op;
		req.key   <= key;
		req.value <= value;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	// Response side: random back-pressure, plus one long hold when asked.
	initial begin
		int g;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (stall_now) begin
				rsp.ready <= 1'b0;
				repeat (600) @(posedge clk);
				stall_now = 1'b0;
			end
			g = gap_len();
			if (g > 0) begin
				rsp.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// Cycle limit for the whole run.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("hopscotch_hash_table_tb failed");
				$finish;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		logic [63:0] k;
		int r;
		stall_now = 1'b0;
		arst_n    <= 1'b0;
		req.valid <= 1'b0;
		req.op    <= OP_LOOKUP;
		req.key   <= '0;
		req.value <= '0;
		fill_pool(end_pool, 24, 992, 1023);
		fill_pool(mid_pool, 48, 500, 507);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty table, key and value extremes, duplicates, unused code.
		send(OP_LOOKUP, 64'd0, 32'd0);
		send(OP_REMOVE, '1, 32'd0);
		send(OP_INSERT, 64'd0, 32'd0);
		send(OP_INSERT, '1, '1);
		send(OP_LOOKUP, 64'd0, '1);
		send(OP_LOOKUP, '1, 32'd0);
		send(OP_INSERT, '1, 32'h5a5a_a5a5);
		send(OP_LOOKUP, '1, 32'd0);
		send(OP_REMOVE, '1, 32'd0);
		send(OP_LOOKUP, '1, 32'd0);
		send(OP_REMOVE, 64'd0, 32'd0);
		send(OP_REMOVE, 64'd0, 32'd0);
		send(OP_UNUSED, '1, '1);
		send(OP_UNUSED, end_pool[0], 32'd7);
		// Near the table end: probing can run out of buckets and report full.
		for (int i = 0; i < 11; i++)
			send(OP_INSERT, end_pool[i], $urandom());

		// Random part: mostly clustered keys, some fully random ones.
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 150)
				stall_now = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 75) begin
				if ($urandom_range(0, 2) == 0)
					k = end_pool[$urandom_range(0, end_pool.size() - 1)];
				else
					k = mid_pool[$urandom_range(0, mid_pool.size() - 1)];
				r = $urandom_range(0, 99);
				send(r < 50 ? OP_INSERT : (r < 78 ? OP_LOOKUP : OP_REMOVE), k, $urandom());
			end else begin
				send(op_t'($urandom_range(0, 3)), rand_key(), $urandom());
			end
		end
		req.valid <= 1'b0;

		// Wait on the clock so that the last transfer is already counted as pending.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("hopscotch_hash_table_tb passed");
		else
			$display("hopscotch_hash_table_tb failed");
		$finish;
	end

endmodule
